>>> sv/gpf_pkg.sv
// Shared types and constants for the gravity pair force engine.
package gpf_pkg;
	localparam logic signed [47:0] FMAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [47:0] FMIN = 48'sh8000_0000_0000;
	localparam logic [18:0] G_FIX = 19'd437125;

	localparam logic [1:0] REQ_LOAD   = 2'd0;
	localparam logic [1:0] REQ_REMOTE = 2'd1;
	localparam logic [1:0] REQ_PAIR   = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	typedef struct packed {
		logic        [31:0] mass;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [47:0] fx;
		logic signed [47:0] fy;
		logic               sat;
	} prt_rec_t;

	typedef struct packed {
		logic               done;
		logic               coin;
		logic               sat;
		logic signed [47:0] tx;
		logic signed [47:0] ty;
	} pull_res_t;
endpackage

>>> sv/gpf_cell.sv
// One particle cell of the rotating ring: holds a particle record.
module gpf_cell
	import gpf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     shift,
	input  logic     load,
	input  prt_rec_t nb_rec,
	input  prt_rec_t ld_rec,
	output prt_rec_t rec
);
	prt_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (load) begin
			rec_q <= ld_rec;
		end else if (shift) begin
			rec_q <= nb_rec;
		end
	end

	assign rec = rec_q;
endmodule

>>> sv/gpf_pull.sv
// Serial force evaluation: shift-add multiplier, bitwise square root, restoring divider.
module gpf_pull
	import gpf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic        [31:0] ma,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic        [31:0] mb,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by,
	output pull_res_t          res
);
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_SQX  = 4'd1;
	localparam logic [3:0] PH_SQY  = 4'd2;
	localparam logic [3:0] PH_SQRT = 4'd3;
	localparam logic [3:0] PH_DD   = 4'd4;
	localparam logic [3:0] PH_D3   = 4'd5;
	localparam logic [3:0] PH_GM   = 4'd6;
	localparam logic [3:0] PH_BASE = 4'd7;
	localparam logic [3:0] PH_NX   = 4'd8;
	localparam logic [3:0] PH_DVX  = 4'd9;
	localparam logic [3:0] PH_NY   = 4'd10;
	localparam logic [3:0] PH_DVY  = 4'd11;

	logic [3:0]   ph_q;
	logic [5:0]   cnt_q;
	logic         sxn_q, syn_q;
	logic [31:0]  adx_q, ady_q, ma_q, mb_q;
	logic [83:0]  mcand_q;
	logic [33:0]  mplier_q;
	logic [117:0] acc_q;
	logic [65:0]  d2_q;
	logic [33:0]  srem_q;
	logic [32:0]  root_q;
	logic [97:0]  d3_q;
	logic [82:0]  base_q;
	logic [97:0]  drem_q;
	logic [47:0]  dlo_q, dq_q, qx_q, qy_q;
	logic         dsat_q, sat_q, coin_q, done_q;

	logic [32:0]  dx_c, dy_c;
	logic [31:0]  adx_c, ady_c;
	logic [117:0] mul_next;
	logic         mul_last;
	logic [65:0]  d2_sum;
	logic [35:0]  srem_t, trial, srem_d;
	logic         sge;
	logic [33:0]  srem_n;
	logic [32:0]  root_n;
	logic [98:0]  dt, dsub;
	logic         dge;
	logic [97:0]  drem_n;
	logic [47:0]  dq_n, qfin;
	logic         qsat;
	logic [97:0]  dhi;

	assign dx_c  = {bx[31], bx} - {ax[31], ax};
	assign dy_c  = {by[31], by} - {ay[31], ay};
	assign adx_c = dx_c[32] ? 32'(-dx_c) : dx_c[31:0];
	assign ady_c = dy_c[32] ? 32'(-dy_c) : dy_c[31:0];

	assign mul_next = {acc_q[116:0], 1'b0} + (mplier_q[33] ? {34'd0, mcand_q} : 118'd0);
	assign mul_last = cnt_q == 6'd33;
	assign d2_sum   = d2_q + mul_next[65:0];

	assign srem_t = {srem_q, d2_q[65:64]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign sge    = srem_t >= trial;
	assign srem_d = srem_t - trial;
	assign srem_n = sge ? srem_d[33:0] : srem_t[33:0];
	assign root_n = {root_q[31:0], sge};

	assign dt     = {drem_q, dlo_q[47]};
	assign dge    = dt >= {1'b0, d3_q};
	assign dsub   = dt - {1'b0, d3_q};
	assign drem_n = dge ? dsub[97:0] : dt[97:0];
	assign dq_n   = {dq_q[46:0], dge};
	assign qsat   = dsat_q || dq_n[47];
	assign qfin   = qsat ? FMAX : dq_n;
	assign dhi    = {30'd0, mul_next[115:48]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE; cnt_q <= '0; sxn_q <= 1'b0; syn_q <= 1'b0;
			adx_q <= '0; ady_q <= '0; ma_q <= '0; mb_q <= '0;
			mcand_q <= '0; mplier_q <= '0; acc_q <= '0; d2_q <= '0;
			srem_q <= '0; root_q <= '0; d3_q <= '0; base_q <= '0;
			drem_q <= '0; dlo_q <= '0; dq_q <= '0; qx_q <= '0; qy_q <= '0;
			dsat_q <= 1'b0; sat_q <= 1'b0; coin_q <= 1'b0; done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (ph_q)
				PH_IDLE: begin
					if (start) begin
						sxn_q <= dx_c[32]; syn_q <= dy_c[32];
						adx_q <= adx_c; ady_q <= ady_c;
						ma_q <= ma; mb_q <= mb;
						mcand_q <= {52'd0, adx_c}; mplier_q <= {2'd0, adx_c};
						acc_q <= '0; cnt_q <= '0;
						coin_q <= 1'b0; sat_q <= 1'b0;
						ph_q <= PH_SQX;
					end
				end
				PH_SQX, PH_SQY, PH_DD, PH_D3, PH_GM, PH_BASE, PH_NX, PH_NY: begin
					acc_q <= mul_next;
					mplier_q <= {mplier_q[32:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (mul_last) begin
						acc_q <= '0;
						cnt_q <= '0;
						case (ph_q)
							PH_SQX: begin
								d2_q <= mul_next[65:0];
								mcand_q <= {52'd0, ady_q}; mplier_q <= {2'd0, ady_q};
								ph_q <= PH_SQY;
							end
							PH_SQY: begin
								if (d2_sum == '0) begin
									coin_q <= 1'b1; done_q <= 1'b1; ph_q <= PH_IDLE;
								end else begin
									d2_q <= d2_sum; srem_q <= '0; root_q <= '0;
									ph_q <= PH_SQRT;
								end
							end
							PH_DD: begin
								mcand_q <= {18'd0, mul_next[65:0]};
								mplier_q <= {1'b0, root_q};
								ph_q <= PH_D3;
							end
							PH_D3: begin
								d3_q <= mul_next[97:0];
								mcand_q <= {52'd0, ma_q}; mplier_q <= {15'd0, G_FIX};
								ph_q <= PH_GM;
							end
							PH_GM: begin
								mcand_q <= {33'd0, mul_next[50:0]}; mplier_q <= {2'd0, mb_q};
								ph_q <= PH_BASE;
							end
							PH_BASE: begin
								base_q <= mul_next[82:0];
								mcand_q <= {1'b0, mul_next[82:0]}; mplier_q <= {2'd0, adx_q};
								ph_q <= PH_NX;
							end
							PH_NX, PH_NY: begin
								dsat_q <= dhi >= d3_q;
								drem_q <= dhi; dlo_q <= mul_next[47:0]; dq_q <= '0;
								ph_q <= (ph_q == PH_NX) ? PH_DVX : PH_DVY;
							end
							default: ph_q <= PH_IDLE;
						endcase
					end
				end
				PH_SQRT: begin
					srem_q <= srem_n; root_q <= root_n;
					d2_q <= {d2_q[63:0], 2'b00};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) begin
						mcand_q <= {51'd0, root_n}; mplier_q <= {1'b0, root_n};
						acc_q <= '0; cnt_q <= '0;
						ph_q <= PH_DD;
					end
				end
				PH_DVX, PH_DVY: begin
					drem_q <= drem_n; dq_q <= dq_n;
					dlo_q <= {dlo_q[46:0], 1'b0};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd47) begin
						sat_q <= sat_q | qsat;
						cnt_q <= '0;
						if (ph_q == PH_DVX) begin
							qx_q <= qfin;
							mcand_q <= {1'b0, base_q}; mplier_q <= {2'd0, ady_q};
							acc_q <= '0;
							ph_q <= PH_NY;
						end else begin
							qy_q <= qfin; done_q <= 1'b1;
							ph_q <= PH_IDLE;
						end
					end
				end
				default: ph_q <= PH_IDLE;
			endcase
		end
	end

	assign res.done = done_q;
	assign res.coin = coin_q;
	assign res.sat  = sat_q;
	assign res.tx   = sxn_q ? -$signed(qx_q) : $signed(qx_q);
	assign res.ty   = syn_q ? -$signed(qy_q) : $signed(qy_q);
endmodule

>>> sv/gravity_pair_force_accumulate.sv
// Top level: direct-sum 2D gravity force engine over a rotating ring of particle cells.
// Local particles sit in a ring of min(MAX_PARTICLES, 64) cells that rotates one slot per step,
// the slot at the head meeting a single serial force unit. A load writes its cell while idle. One force
// evaluation runs shift-add multiplies, a bitwise square root and two restoring divides, all in
// that one unit; a coincident pair ends after the two squares. A remote item evaluates one force
// per used cell and passes unused cells; a pairwise item evaluates each pair once over one full
// ring turn per particle; a readout item takes one cycle per cell while the output is taken, and
// the last result may wait in the output register while the next item is taken.
module gravity_pair_force_accumulate
	import gpf_pkg::*;
#(
	parameter int MAX_PARTICLES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic        [1:0]  req_type,
	input  logic        [5:0]  particle_index,
	input  logic        [31:0] mass,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [5:0]  out_index,
	output logic signed [47:0] force_x,
	output logic signed [47:0] force_y,
	output logic               zero_distance_seen,
	output logic               saturated,
	output logic               last,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [6:0]  cfg_data
);
	localparam int ROW = (MAX_PARTICLES < 64) ? MAX_PARTICLES : 64;
	localparam int IW  = (ROW > 1) ? $clog2(ROW) : 1;
	localparam logic [IW-1:0] LAST_SLOT = IW'(ROW - 1);
	localparam logic [6:0]    ROW7      = 7'(ROW);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_REM   = 3'd1;
	localparam logic [2:0] ST_PCAP  = 3'd2;
	localparam logic [2:0] ST_PWALK = 3'd3;
	localparam logic [2:0] ST_BACK  = 3'd4;
	localparam logic [2:0] ST_READ  = 3'd5;

	logic [2:0]         state_q;
	logic [IW-1:0]      hs_q, pi_q, hs_nxt;
	logic               busy_q, coin_q;
	logic [6:0]         cnt_q, n7, hs7, pi7;
	logic [31:0]        rm_mass_q;
	logic signed [31:0] rm_x_q, rm_y_q;
	prt_rec_t           piv_q;
	logic               ov_q, ov_last_q, ov_zero_q, ov_sat_q;
	logic [5:0]         ov_idx_q;
	logic signed [47:0] ov_fx_q, ov_fy_q;

	prt_rec_t           rec [ROW];
	prt_rec_t           nb [ROW];
	prt_rec_t           head, head_out, ld_rec, head_add, head_sub, piv_add;
	logic [ROW-1:0]     ld_hit;
	logic               rot, start_c, in_use, out_free, load_acc;
	pull_res_t          pr;
	logic [31:0]        a_mass, b_mass;
	logic signed [31:0] a_x, a_y, b_x, b_y;

	function automatic prt_rec_t add_term(prt_rec_t r, logic signed [47:0] tx,
		logic signed [47:0] ty, logic s);
		prt_rec_t o;
		logic [48:0] sx, sy;
		o  = r;
		sx = {r.fx[47], r.fx} + {tx[47], tx};
		sy = {r.fy[47], r.fy} + {ty[47], ty};
		o.fx = (sx[48] != sx[47]) ? (sx[48] ? FMIN : FMAX) : $signed(sx[47:0]);
		o.fy = (sy[48] != sy[47]) ? (sy[48] ? FMIN : FMAX) : $signed(sy[47:0]);
		o.sat = r.sat | s | (sx[48] != sx[47]) | (sy[48] != sy[47]);
		return o;
	endfunction

	assign head     = rec[0];
	assign n7       = (cnt_q == 7'd0) ? 7'd1 : ((cnt_q > ROW7) ? ROW7 : cnt_q);
	assign hs7      = 7'(hs_q);
	assign pi7      = 7'(pi_q);
	assign in_use   = hs7 < n7;
	assign hs_nxt   = (hs_q == LAST_SLOT) ? '0 : hs_q + 1'b1;
	assign out_free = !ov_q || out_ready;
	assign in_ready = state_q == ST_IDLE;
	assign cfg_ready = 1'b1;
	assign load_acc = in_valid && in_ready && (req_type == REQ_LOAD);

	assign ld_rec.mass = mass;
	assign ld_rec.px   = pos_x;
	assign ld_rec.py   = pos_y;
	assign ld_rec.fx   = '0;
	assign ld_rec.fy   = '0;
	assign ld_rec.sat  = 1'b0;

	for (genvar c = 0; c < ROW; c++) begin : g_cell
		assign ld_hit[c] = load_acc && (particle_index == 6'(c));
		if (c == ROW - 1) begin : g_tail
			assign nb[c] = head_out;
		end else begin : g_body
			assign nb[c] = rec[c+1];
		end
		gpf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (rot),
			.load   (ld_hit[c]),
			.nb_rec (nb[c]),
			.ld_rec (ld_rec),
			.rec    (rec[c])
		);
	end

	assign a_mass = (state_q == ST_REM) ? head.mass : piv_q.mass;
	assign a_x    = (state_q == ST_REM) ? head.px : piv_q.px;
	assign a_y    = (state_q == ST_REM) ? head.py : piv_q.py;
	assign b_mass = (state_q == ST_REM) ? rm_mass_q : head.mass;
	assign b_x    = (state_q == ST_REM) ? rm_x_q : head.px;
	assign b_y    = (state_q == ST_REM) ? rm_y_q : head.py;

	gpf_pull u_pull (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_c),
		.ma     (a_mass),
		.ax     (a_x),
		.ay     (a_y),
		.mb     (b_mass),
		.bx     (b_x),
		.by     (b_y),
		.res    (pr)
	);

	assign head_add = add_term(head, pr.tx, pr.ty, pr.sat);
	assign head_sub = add_term(head, -pr.tx, -pr.ty, pr.sat);
	assign piv_add  = add_term(piv_q, pr.tx, pr.ty, pr.sat);

	always_comb begin
		head_out = head;
		rot      = 1'b0;
		start_c  = 1'b0;
		case (state_q)
			ST_REM: begin
				if (!in_use) begin
					rot = 1'b1;
				end else if (pr.done) begin
					rot = 1'b1;
					if (!pr.coin) head_out = head_add;
				end else if (!busy_q) begin
					start_c = 1'b1;
				end
			end
			ST_PCAP: rot = 1'b1;
			ST_PWALK: begin
				if (hs_q == pi_q) begin
					rot = 1'b1;
					head_out = piv_q;
				end else if (hs7 > pi7 && in_use) begin
					if (pr.done) begin
						rot = 1'b1;
						if (!pr.coin) head_out = head_sub;
					end else if (!busy_q) begin
						start_c = 1'b1;
					end
				end else begin
					rot = 1'b1;
				end
			end
			ST_BACK: rot = hs_q != '0;
			ST_READ: rot = !in_use || out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; hs_q <= '0; pi_q <= '0; busy_q <= 1'b0;
			cnt_q <= 7'd64; coin_q <= 1'b0;
			rm_mass_q <= '0; rm_x_q <= '0; rm_y_q <= '0; piv_q <= '0;
			ov_q <= 1'b0; ov_last_q <= 1'b0; ov_zero_q <= 1'b0; ov_sat_q <= 1'b0;
			ov_idx_q <= '0; ov_fx_q <= '0; ov_fy_q <= '0;
		end else begin
			if (cfg_valid) cnt_q <= cfg_data;
			if (start_c) busy_q <= 1'b1;
			if (pr.done) busy_q <= 1'b0;
			if (pr.done && pr.coin) coin_q <= 1'b1;
			if (rot) hs_q <= hs_nxt;
			if (ov_q && out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (req_type)
							REQ_LOAD: coin_q <= 1'b0;
							REQ_REMOTE: begin
								rm_mass_q <= mass; rm_x_q <= pos_x; rm_y_q <= pos_y;
								state_q <= ST_REM;
							end
							REQ_PAIR: begin
								pi_q <= '0;
								state_q <= ST_PCAP;
							end
							REQ_READ: state_q <= ST_READ;
							default: ;
						endcase
					end
				end
				ST_REM: if (rot && hs_q == LAST_SLOT) state_q <= ST_IDLE;
				ST_PCAP: begin
					piv_q <= head;
					state_q <= ST_PWALK;
				end
				ST_PWALK: begin
					if (hs_q == pi_q) begin
						if (pi7 + 7'd1 < n7) begin
							pi_q <= pi_q + 1'b1;
							state_q <= ST_PCAP;
						end else begin
							state_q <= ST_BACK;
						end
					end else if (pr.done && !pr.coin) begin
						piv_q <= piv_add;
					end
				end
				ST_BACK: if (hs_q == '0) state_q <= ST_IDLE;
				ST_READ: begin
					if (in_use && out_free) begin
						ov_q      <= 1'b1;
						ov_idx_q  <= 6'(hs_q);
						ov_fx_q   <= head.fx;
						ov_fy_q   <= head.fy;
						ov_zero_q <= coin_q;
						ov_sat_q  <= head.sat;
						ov_last_q <= hs7 == n7 - 7'd1;
					end
					if (rot && hs_q == LAST_SLOT) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid          = ov_q;
	assign out_index          = ov_idx_q;
	assign force_x            = ov_fx_q;
	assign force_y            = ov_fy_q;
	assign zero_distance_seen = ov_zero_q;
	assign saturated          = ov_sat_q;
	assign last               = ov_last_q;

	a_idle_home: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> hs_q == '0)
		else $error("ring not at home slot while idle");
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		start_c |-> !busy_q)
		else $error("force unit started while busy");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pr.done |-> busy_q)
		else $error("force unit result without request");
	a_out_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == ST_READ)
		else $error("result beat outside readout");
endmodule
